// File: rtl/rre_pkg.sv
`default_nettype none

package rre_pkg;

  localparam logic [15:0] RESET_WINDOW = 16'd64;

  // word index of the window count register (paddr[2])
  localparam logic REG_WINDOW = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SCALE,
    S_SHARE_GO,
    S_SHARE_WAIT,
    S_ACCUM,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_NEWTON_GO,
    S_NEWTON_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    DSEL_SHARE,
    DSEL_MEAN,
    DSEL_NEWTON
  } dsel_t;

  typedef struct packed {
    logic  load;
    logic  mul_sq;
    logic  mul_n;
    logic  div_start;
    dsel_t div_sel;
    logic  upd_sum;
    logic  upd_est;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_full;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/rre_div.sv
`default_nettype none

module rre_div
  import rre_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient
);

  logic [15:0] rem;
  logic [15:0] dvs;
  logic [4:0]  cnt;
  logic [16:0] shifted;
  logic        ge;
  logic [16:0] diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem, quotient[31]};
    ge      = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= 16'd0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[30:0], ge};
      rem      <= ge ? diff[15:0] : shifted[15:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/rre_datapath.sv
`default_nettype none

module rre_datapath
  import rre_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output status_t          status,
  input  wire logic [15:0] window_count,
  input  wire logic [15:0] sample,
  output logic [15:0]      rms,
  output logic             rms_valid,
  input  wire logic        rms_stall
);

  logic [15:0] x;
  logic [15:0] e;
  logic [15:0] n;
  logic [15:0] est;
  logic [31:0] esq;
  logic [31:0] xsq;
  logic [31:0] sum;
  logic [47:0] scaled;
  logic [15:0] e_div;
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_busy;
  logic [31:0] div_q;
  logic [31:0] newton;

  always_comb begin
    scaled = {16'd0, esq} * {32'd0, n};
    e_div  = (e == 16'd0) ? 16'd1 : e;
    newton = {16'd0, e_div} + div_q;
    case (cmd.div_sel)
      DSEL_SHARE: begin
        div_dividend = sum;
        div_divisor  = n;
      end
      DSEL_MEAN: begin
        div_dividend = sum;
        div_divisor  = n;
      end
      DSEL_NEWTON: begin
        div_dividend = div_q;
        div_divisor  = e_div;
      end
      default: begin
        div_dividend = sum;
        div_divisor  = n;
      end
    endcase
  end

  rre_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= sample;
      e <= est;
      n <= (window_count == 16'd0) ? 16'd1 : window_count;
    end
    if (cmd.mul_sq) begin
      esq <= {16'd0, e} * {16'd0, e};
      xsq <= {16'd0, x} * {16'd0, x};
    end
    if (cmd.mul_n) begin
      sum <= scaled[31:0];
    end else if (cmd.upd_sum) begin
      sum <= sum - div_q + xsq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est       <= 16'd0;
      rms_valid <= 1'b0;
    end else if (cmd.upd_est) begin
      est       <= newton[16:1];
      rms_valid <= 1'b1;
    end else if (!rms_stall) begin
      rms_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_est) begin
      rms <= newton[16:1];
    end
  end

  assign status.div_busy = div_busy;
  assign status.out_full = rms_valid & rms_stall;

endmodule

`default_nettype wire

// File: rtl/rre_ctrl.sv
`default_nettype none

module rre_ctrl
  import rre_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    sample_valid,
  output logic         sample_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.div_sel  = DSEL_SHARE;
    sample_stall = 1'b1;
    case (state)
      S_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.mul_sq = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.mul_n  = 1'b1;
        state_next = S_SHARE_GO;
      end
      S_SHARE_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_SHARE;
        state_next    = S_SHARE_WAIT;
      end
      S_SHARE_WAIT: begin
        if (!status.div_busy) begin
          state_next = S_ACCUM;
        end
      end
      S_ACCUM: begin
        // drop one window share, add the new square
        cmd.upd_sum = 1'b1;
        state_next  = S_MEAN_GO;
      end
      S_MEAN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_MEAN;
        state_next    = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (!status.div_busy) begin
          state_next = S_NEWTON_GO;
        end
      end
      S_NEWTON_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_NEWTON;
        state_next    = S_NEWTON_WAIT;
      end
      S_NEWTON_WAIT: begin
        cmd.div_sel = DSEL_NEWTON;
        if (!status.div_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.div_sel = DSEL_NEWTON;
        // hold until the output register is free
        if (!status.out_full) begin
          cmd.upd_est = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/running_rms_estimator_top.sv
`default_nettype none

// channel  | valid        | stall        | payload
// ---------+--------------+--------------+-------------------
// sample   | sample_valid | sample_stall | sample[15:0]
// rms      | rms_valid    | rms_stall    | rms[15:0]
// config   | apb write    | pready = 1   | window_count @ 0x0
//
// one request runs load, square and scale, then three 32-bit by 16-bit
// divisions one after another on a single radix-2 divider (window share,
// mean, newton step), with the accumulate between the first two; the
// newton result is then registered as the new estimate and the output.
// a new sample is taken only while the sequencer is idle; the result register
// lets it start before the previous result is taken, and it waits at the end
// if that result is still stalled. reset is synchronous: estimate 0, window 64.

module running_rms_estimator_top
  import rre_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] sample,
  input  wire logic        sample_valid,
  output logic             sample_stall,
  output logic [15:0]      rms,
  output logic             rms_valid,
  input  wire logic        rms_stall,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] window_count;
  cmd_t        cmd;
  status_t     status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= RESET_WINDOW;
    end else if (psel && penable && pwrite && (paddr[2] == REG_WINDOW)) begin
      window_count <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_WINDOW) begin
      prdata = {16'd0, window_count};
    end
  end

  rre_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  rre_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .window_count (window_count),
    .sample       (sample),
    .rms          (rms),
    .rms_valid    (rms_valid),
    .rms_stall    (rms_stall)
  );

endmodule

`default_nettype wire

// File: test/running_rms_estimator_top_tb.sv
module running_rms_estimator_top_tb;
  import rre_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int RESET_LEN   = 8;
  localparam int SETTLE_LEN  = 140;   // idle time, enough for one full request to finish
  localparam int STUCK_LIMIT = 3000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;

  typedef enum {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] value;
    bit          typed;
    logic [15:0] want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic [15:0] sample;
  logic        sample_valid;
  logic        sample_stall;
  logic [15:0] rms;
  logic        rms_valid;
  logic        rms_stall;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // tracked copy of the block state
  logic [15:0] est_track;
  logic [15:0] win_track;
  logic [15:0] rms_pending[$];

  // typed expectation that rides along with the request on the wire
  bit          typed_flag;
  logic [15:0] typed_rms;

  int          err_cnt;
  int          n_requests;
  int          n_checked;
  int          n_windows;
  int          n_zero_est;
  int          gap_pct;
  int          stall_pct;
  bit          quiet;
  int          stuck_cycles;

  stim_row_t   dir_rows [0:23];

  running_rms_estimator_top DUT (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .rms         (rms),
    .rms_valid   (rms_valid),
    .rms_stall   (rms_stall),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // one newton square-root step on the running sum of squares
  function automatic logic [15:0] rms_update(input logic [15:0] est, input logic [15:0] win,
                                             input logic [15:0] x);
    logic [31:0] n;
    logic [31:0] e;
    logic [31:0] d;
    logic [31:0] acc;
    logic [31:0] t;
    logic [63:0] prod;
    logic [32:0] s33;
    n    = (win == 16'd0) ? 32'd1 : {16'd0, win};
    e    = {16'd0, est};
    prod = 64'(n) * 64'(e) * 64'(e);
    acc  = prod[31:0];
    acc  = acc - acc / n;
    acc  = acc + {16'd0, x} * {16'd0, x};
    d    = (e == 32'd0) ? 32'd1 : e;
    s33  = {1'b0, d} + {1'b0, (acc / n) / d};
    t    = s33[31:0] >> 1;
    return t[15:0];
  endfunction

  function automatic int gap_len();
    if (quiet || $urandom_range(0, 99) >= gap_pct) return 0;
    return $urandom_range(1, 15);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_sample(input logic [15:0] val, input bit typed, input logic [15:0] want);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      sample_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample       = val;
    typed_flag   = typed;
    typed_rms    = want;
    sample_valid = 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    sample_valid = 1'b0;
    while (rms_pending.size() != 0) @(negedge clk);
    repeat (SETTLE_LEN) @(negedge clk);
  endtask

  // apb write of the window count, then read it back
  task automatic write_window(input logic [15:0] w);
    logic [31:0] junk;
    junk    = $urandom;
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {REG_WINDOW, 2'b00};
    pwdata  = {junk[31:16], w};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    pwdata  = junk;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== w)
      $error("window_count: expected %0d, actual %0d", w, prdata[15:0]);
    if (prdata[15:0] !== w) err_cnt++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    n_windows++;
  endtask

  // rms result stall in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    rms_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && !quiet && $urandom_range(0, 99) < stall_pct)
        stall_left = $urandom_range(1, 15);
      if (stall_left > 0) begin
        rms_stall = 1'b1;
        stall_left--;
      end else begin
        rms_stall = 1'b0;
      end
    end
  end

  // track accepted requests and check results
  always @(posedge clk) begin
    logic [15:0] nxt;
    logic [15:0] want;
    if (rst) begin
      est_track = 16'd0;
      win_track = RESET_WINDOW;
    end else begin
      if (sample_valid && !sample_stall) begin
        if (est_track == 16'd0) n_zero_est++;
        nxt       = rms_update(est_track, win_track, sample);
        est_track = nxt;
        rms_pending.push_back(typed_flag ? typed_rms : nxt);
        n_requests++;
      end
      if (rms_valid && !rms_stall) begin
        if (rms_pending.size() == 0) begin
          $error("rms: result with no request pending, actual %0d", rms);
          err_cnt++;
        end else begin
          want = rms_pending.pop_front();
          n_checked++;
          if (rms !== want) begin
            $error("rms: expected %0d, actual %0d", want, rms);
            err_cnt++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW)
        win_track = pwdata[15:0];
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (rms_valid && !rms_stall) ||
        (psel && penable && pready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("[running_rms_estimator_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int          ph;
    int          i;
    int          run_left;
    int          run_mode;
    logic [15:0] run_level;
    logic [15:0] v;
    logic [15:0] w;

    dir_rows = '{
      // reset state: estimate zero, window 64
      '{ROW_SAMPLE, 16'd0,     1'b1, 16'd0},
      '{ROW_SAMPLE, 16'd1,     1'b1, 16'd0},
      '{ROW_SAMPLE, 16'hFFFF,  1'b1, 16'hFC00},
      '{ROW_SAMPLE, 16'hFFFF,  1'b0, 16'd0},
      '{ROW_SAMPLE, 16'd0,     1'b0, 16'd0},
      '{ROW_SAMPLE, 16'd0,     1'b0, 16'd0},
      '{ROW_WINDOW, 16'd1,     1'b0, 16'd0},
      '{ROW_SAMPLE, 16'hFFFF,  1'b0, 16'd0},
      '{ROW_SAMPLE, 16'd0,     1'b0, 16'd0},
      '{ROW_SAMPLE, 16'd12345, 1'b0, 16'd0},
      '{ROW_WINDOW, 16'hFFFF,  1'b0, 16'd0},
      '{ROW_SAMPLE, 16'hFFFF,  1'b0, 16'd0},
      '{ROW_SAMPLE, 16'd1,     1'b0, 16'd0},
      '{ROW_SAMPLE, 16'd0,     1'b0, 16'd0},
      // zero window behaves as one
      '{ROW_WINDOW, 16'd0,     1'b0, 16'd0},
      '{ROW_SAMPLE, 16'hFFFF,  1'b0, 16'd0},
      '{ROW_SAMPLE, 16'h8000,  1'b0, 16'd0},
      '{ROW_SAMPLE, 16'd0,     1'b0, 16'd0},
      '{ROW_WINDOW, 16'd2,     1'b0, 16'd0},
      '{ROW_SAMPLE, 16'd40000, 1'b0, 16'd0},
      '{ROW_SAMPLE, 16'd255,   1'b0, 16'd0},
      '{ROW_WINDOW, 16'd64,    1'b0, 16'd0},
      '{ROW_SAMPLE, 16'hFFFF,  1'b0, 16'd0},
      '{ROW_SAMPLE, 16'd0,     1'b0, 16'd0}
    };

    err_cnt      = 0;
    n_requests   = 0;
    n_checked    = 0;
    n_windows    = 0;
    n_zero_est   = 0;
    quiet        = 1'b0;
    gap_pct      = 30;
    stall_pct    = 5;
    stuck_cycles = 0;
    typed_flag   = 1'b0;
    typed_rms    = 16'd0;
    rst          = 1'b1;
    sample       = 16'd0;
    sample_valid = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = 3'd0;
    pwdata       = 32'd0;
    run_left     = 0;
    run_mode     = 0;
    run_level    = 16'd0;

    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_WINDOW) begin
        wait_idle();
        write_window(dir_rows[r].value);
      end else begin
        send_sample(dir_rows[r].value, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       w = 16'd1;
        1:       w = 16'hFFFF;
        2:       w = 16'd0;
        3:       w = 16'd2;
        4:       w = 16'($urandom_range(1, 64));
        5:       w = 16'($urandom_range(1, 65535));
        6:       w = RESET_WINDOW;
        default: w = 16'($urandom_range(3, 1000));
      endcase
      wait_idle();
      write_window(w);
      case ($urandom_range(0, 3))
        0:       gap_pct = 0;
        1:       gap_pct = 25;
        2:       gap_pct = 50;
        default: gap_pct = 90;
      endcase
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 2;
        2:       stall_pct = 8;
        default: stall_pct = 25;
      endcase
      if (ph == PHASES - 1) quiet = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // runs of one kind of signal so the estimate can settle or decay
        if (run_left == 0) begin
          run_left  = $urandom_range(1, 40);
          run_mode  = $urandom_range(0, 4);
          run_level = 16'($urandom);
        end
        case (run_mode)
          0:       v = 16'($urandom);
          1:       v = 16'($urandom_range(0, 255));
          2:       v = run_level ^ 16'($urandom_range(0, 3));
          3:       v = 16'd0;
          default: v = 16'hFFFF;
        endcase
        run_left--;
        send_sample(v, 1'b0, 16'd0);
      end
    end

    sample_valid = 1'b0;
    while (rms_pending.size() != 0) @(negedge clk);
    repeat (SETTLE_LEN) @(negedge clk);

    $display("covered %0d samples (%0d from a zero estimate), %0d results checked",
             n_requests, n_zero_est, n_checked);
    $display("window count written %0d times, including 0, 1, 2, 64 and 65535", n_windows);
    if (err_cnt == 0) begin
      $display("[running_rms_estimator_top] OK");
    end else begin
      $display("[running_rms_estimator_top] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rre_pkg.sv
rtl/rre_div.sv
rtl/rre_datapath.sv
rtl/rre_ctrl.sv
rtl/running_rms_estimator_top.sv
test/running_rms_estimator_top_tb.sv
